[rtl/cobs_pkg.sv]
// shared types and constants for the channel occupancy bucket statistics block
package cobs_pkg;

	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_SKIP   = 2'd1;
	localparam logic [1:0] REQ_OWN_RX = 2'd2;

	localparam logic [1:0] CFG_BUCKET_MS   = 2'd0;
	localparam logic [1:0] CFG_RAIL_DBM10  = 2'd1;
	localparam logic [1:0] CFG_OCCUPIED    = 2'd2;

	localparam logic [31:0]        BUCKET_MS_RESET = 32'd1000;
	localparam logic signed [15:0] RAIL_RESET      = -16'sd32768;
	localparam logic signed [15:0] OCCUPIED_RESET  = -16'sd900;

	localparam logic signed [15:0] NO_READING = -16'sd32768;
	localparam logic signed [47:0] SUM_MAX    = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] SUM_MIN    = {1'b1, {47{1'b0}}};

	// running figures of the open bucket
	typedef struct packed {
		logic [31:0]        open_ms;
		logic [31:0]        n_samples;
		logic [31:0]        n_skipped;
		logic [31:0]        n_above;
		logic [31:0]        n_own_rx;
		logic signed [15:0] max_level;
		logic signed [15:0] min_level;
		logic signed [47:0] sum_level;
	} bucket_t;

	// one closed bucket as emitted
	typedef struct packed {
		logic [31:0]        bucket_seq;
		logic [31:0]        bucket_start_ms;
		logic [31:0]        bucket_dur_ms;
		logic [31:0]        sample_total;
		logic [31:0]        skip_total;
		logic [31:0]        above_total;
		logic [31:0]        own_rx_total;
		logic signed [15:0] peak_level;
		logic signed [15:0] floor_level;
		logic signed [47:0] level_total;
	} result_t;

	// configuration as seen by the update logic
	typedef struct packed {
		logic [31:0]        bucket_ms;
		logic signed [15:0] rail_dbm10;
		logic signed [15:0] occupied_dbm10;
	} cfg_t;

	localparam bucket_t BUCKET_CLEAR = '{
		open_ms:   32'd0,
		n_samples: 32'd0,
		n_skipped: 32'd0,
		n_above:   32'd0,
		n_own_rx:  32'd0,
		max_level: NO_READING,
		min_level: NO_READING,
		sum_level: 48'sd0
	};

	function automatic logic [31:0] inc_sat(input logic [31:0] c);
		return (c == '1) ? c : c + 32'd1;
	endfunction

endpackage

[rtl/channel_occupancy_bucket_stats_core.sv]
// top level of the channel occupancy bucket statistics block
// Collects signal-strength statistics over fixed-length time buckets. Requests are
// samples, skipped opportunities and own-reception notes; the first sample or skip
// opens bucket 0, and a later one whose timestamp is at least bucket_ms past the
// bucket start closes the open bucket (emitting one result) before it is counted
// into the fresh bucket. Own receptions never close a bucket and are dropped until
// one has opened; request type 3 is ignored. The block takes one request every
// clock cycle while in_stall is low: a request is registered on acceptance, updates
// the running figures through a single layer of compare/add logic when it leaves the
// input register, and the bucket that it closes is loaded into the output register.
// Input stall rises only when the input register holds a request that closes a bucket
// while the output register is still full and stalled.
// Configuration writes are always taken (cfg_ready is tied high) and must be made
// while the block is idle; writes to an index past the register list are ignored.
module channel_occupancy_bucket_stats_core (
	input  logic               clk,
	input  logic               arst_n,

	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,

	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic signed [15:0] rssi,
	input  logic [31:0]        now_ms,

	// closed bucket channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        bucket_seq,
	output logic [31:0]        bucket_start_ms,
	output logic [31:0]        bucket_dur_ms,
	output logic [31:0]        sample_total,
	output logic [31:0]        skip_total,
	output logic [31:0]        above_total,
	output logic [31:0]        own_rx_total,
	output logic signed [15:0] peak_level,
	output logic signed [15:0] floor_level,
	output logic signed [47:0] level_total
);

	// configuration registers
	cobs_pkg::cfg_t     cfg_q;

	// input register
	logic               valid_s1;
	logic [1:0]         req_type_s1;
	logic signed [15:0] rssi_s1;
	logic [31:0]        now_ms_s1;

	// running bucket state
	logic               opened_q;
	logic [31:0]        seq_q;
	cobs_pkg::bucket_t  bucket_q;

	// update results
	logic               opened_nxt;
	logic [31:0]        seq_nxt;
	cobs_pkg::bucket_t  bucket_nxt;
	logic               emit;
	cobs_pkg::result_t  res;

	// output register
	logic               out_valid_q;
	cobs_pkg::result_t  out_q;

	logic               s1_adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bucket_ms      <= cobs_pkg::BUCKET_MS_RESET;
			cfg_q.rail_dbm10     <= cobs_pkg::RAIL_RESET;
			cfg_q.occupied_dbm10 <= cobs_pkg::OCCUPIED_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				cobs_pkg::CFG_BUCKET_MS:  cfg_q.bucket_ms      <= cfg_data;
				cobs_pkg::CFG_RAIL_DBM10: cfg_q.rail_dbm10     <= cfg_data[15:0];
				cobs_pkg::CFG_OCCUPIED:   cfg_q.occupied_dbm10 <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// the registered request moves on unless it closes a bucket and the
	// output register cannot take the result this cycle
	assign s1_adv   = valid_s1 && (!emit || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || s1_adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1 <= req_type;
			rssi_s1     <= rssi;
			now_ms_s1   <= now_ms;
		end
	end

	cobs_update u_update (
		.cfg        (cfg_q),
		.opened     (opened_q),
		.seq        (seq_q),
		.cur        (bucket_q),
		.req_type   (req_type_s1),
		.rssi       (rssi_s1),
		.now_ms     (now_ms_s1),
		.opened_nxt (opened_nxt),
		.seq_nxt    (seq_nxt),
		.nxt        (bucket_nxt),
		.emit       (emit),
		.res        (res)
	);

	// running state commits once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opened_q <= 1'b0;
			seq_q    <= 32'd0;
			bucket_q <= cobs_pkg::BUCKET_CLEAR;
		end else if (s1_adv) begin
			opened_q <= opened_nxt;
			seq_q    <= seq_nxt;
			bucket_q <= bucket_nxt;
		end
	end

	// output register, refilled in the same cycle it is drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit)
			out_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign bucket_seq      = out_q.bucket_seq;
	assign bucket_start_ms = out_q.bucket_start_ms;
	assign bucket_dur_ms   = out_q.bucket_dur_ms;
	assign sample_total    = out_q.sample_total;
	assign skip_total      = out_q.skip_total;
	assign above_total     = out_q.above_total;
	assign own_rx_total    = out_q.own_rx_total;
	assign peak_level      = out_q.peak_level;
	assign floor_level     = out_q.floor_level;
	assign level_total     = out_q.level_total;

endmodule

[rtl/cobs_update.sv]
// next-state and bucket-close logic for one request
module cobs_update (
	input  cobs_pkg::cfg_t      cfg,
	input  logic                opened,
	input  logic [31:0]         seq,
	input  cobs_pkg::bucket_t   cur,
	input  logic [1:0]          req_type,
	input  logic signed [15:0]  rssi,
	input  logic [31:0]         now_ms,
	output logic                opened_nxt,
	output logic [31:0]         seq_nxt,
	output cobs_pkg::bucket_t   nxt,
	output logic                emit,
	output cobs_pkg::result_t   res
);

	logic [31:0]         elapsed;
	logic                is_event;
	logic                roll;
	logic                skip;
	logic signed [48:0]  sum_wide;
	cobs_pkg::bucket_t   base;

	assign elapsed = now_ms - cur.open_ms;

	always_comb begin
		is_event = (req_type == cobs_pkg::REQ_SAMPLE) || (req_type == cobs_pkg::REQ_SKIP);
		emit     = is_event && opened && (elapsed >= cfg.bucket_ms);
		roll     = is_event && (!opened || emit);
		skip     = (req_type == cobs_pkg::REQ_SKIP) || (rssi <= cfg.rail_dbm10);

		res.bucket_seq      = seq;
		res.bucket_start_ms = cur.open_ms;
		res.bucket_dur_ms   = elapsed;
		res.sample_total    = cur.n_samples;
		res.skip_total      = cur.n_skipped;
		res.above_total     = cur.n_above;
		res.own_rx_total    = cur.n_own_rx;
		res.peak_level      = cur.max_level;
		res.floor_level     = cur.min_level;
		res.level_total     = cur.sum_level;

		base = cur;
		if (roll) begin
			base         = cobs_pkg::BUCKET_CLEAR;
			base.open_ms = now_ms;
		end

		sum_wide = {base.sum_level[47], base.sum_level} + 49'(rssi);

		opened_nxt = opened || is_event;
		seq_nxt    = emit ? seq + 32'd1 : seq;
		nxt        = base;

		case (req_type)
			cobs_pkg::REQ_OWN_RX: begin
				if (opened)
					nxt.n_own_rx = cobs_pkg::inc_sat(cur.n_own_rx);
			end
			cobs_pkg::REQ_SAMPLE, cobs_pkg::REQ_SKIP: begin
				if (skip) begin
					nxt.n_skipped = cobs_pkg::inc_sat(base.n_skipped);
				end else begin
					nxt.n_samples = cobs_pkg::inc_sat(base.n_samples);
					if (sum_wide[48] != sum_wide[47])
						nxt.sum_level = sum_wide[48] ? cobs_pkg::SUM_MIN : cobs_pkg::SUM_MAX;
					else
						nxt.sum_level = sum_wide[47:0];
					if (rssi >= cfg.occupied_dbm10)
						nxt.n_above = cobs_pkg::inc_sat(base.n_above);
					if (base.max_level == cobs_pkg::NO_READING || rssi > base.max_level)
						nxt.max_level = rssi;
					if (base.min_level == cobs_pkg::NO_READING || rssi < base.min_level)
						nxt.min_level = rssi;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule
